// ===== src/mesc_pkg.sv =====
package mesc_pkg;

   localparam int ENTITY_SCAN_LIMIT  = 33;
   localparam int NUMERIC_DIGITS_MAX = 8;
   localparam int BUF_DEPTH          = ENTITY_SCAN_LIMIT + 1;
   localparam int ROM_SIZE           = 51;
   localparam int NAME_MAX           = 6;
   localparam int MEM_AW             = 6;
   localparam int MEM_DEPTH          = 1 << MEM_AW;
   localparam int REQQ_DEPTH         = 2;
   localparam int RSPQ_DEPTH         = 4;

   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_HASH   = 8'h23;

   // byte classes
   localparam logic [2:0] CLS_PLAIN  = 3'd0;
   localparam logic [2:0] CLS_PUNCT  = 3'd1;
   localparam logic [2:0] CLS_BSLASH = 3'd2;
   localparam logic [2:0] CLS_AMP    = 3'd3;
   localparam logic [2:0] CLS_SEMI   = 3'd4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
      logic [2:0] cls;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       text_done;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [47:0] name;   // left aligned, first char in the top byte
      logic [2:0]  nlen;
      logic [1:0]  vlen;
      logic [23:0] val;    // first byte in the top byte
   } entry_type;

   function automatic logic [2:0] classify(input logic [7:0] b);
      logic [2:0] c;
      begin
         if (b == CH_BSLASH) c = CLS_BSLASH;
         else if (b == CH_AMP) c = CLS_AMP;
         else if (b == CH_SEMI) c = CLS_SEMI;
         else if (b inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]})
            c = CLS_PUNCT;
         else c = CLS_PLAIN;
         return c;
      end
   endfunction

   function automatic entry_type rom_entry(input logic [5:0] k);
      entry_type e;
      begin
         case (k)
            6'd0:  e = '{"amp", 3'd3, 2'd1, 24'h260000};
            6'd1:  e = '{"lt", 3'd2, 2'd1, 24'h3C0000};
            6'd2:  e = '{"gt", 3'd2, 2'd1, 24'h3E0000};
            6'd3:  e = '{"quot", 3'd4, 2'd1, 24'h220000};
            6'd4:  e = '{"apos", 3'd4, 2'd1, 24'h270000};
            6'd5:  e = '{"nbsp", 3'd4, 2'd2, 24'hC2A000};
            6'd6:  e = '{"copy", 3'd4, 2'd2, 24'hC2A900};
            6'd7:  e = '{"reg", 3'd3, 2'd2, 24'hC2AE00};
            6'd8:  e = '{"trade", 3'd5, 2'd3, 24'hE284A2};
            6'd9:  e = '{"hellip", 3'd6, 2'd3, 24'hE280A6};
            6'd10: e = '{"mdash", 3'd5, 2'd3, 24'hE28094};
            6'd11: e = '{"ndash", 3'd5, 2'd3, 24'hE28093};
            6'd12: e = '{"lsquo", 3'd5, 2'd3, 24'hE28098};
            6'd13: e = '{"rsquo", 3'd5, 2'd3, 24'hE28099};
            6'd14: e = '{"ldquo", 3'd5, 2'd3, 24'hE2809C};
            6'd15: e = '{"rdquo", 3'd5, 2'd3, 24'hE2809D};
            6'd16: e = '{"laquo", 3'd5, 2'd2, 24'hC2AB00};
            6'd17: e = '{"raquo", 3'd5, 2'd2, 24'hC2BB00};
            6'd18: e = '{"deg", 3'd3, 2'd2, 24'hC2B000};
            6'd19: e = '{"plusmn", 3'd6, 2'd2, 24'hC2B100};
            6'd20: e = '{"times", 3'd5, 2'd2, 24'hC39700};
            6'd21: e = '{"divide", 3'd6, 2'd2, 24'hC3B700};
            6'd22: e = '{"frac12", 3'd6, 2'd2, 24'hC2BD00};
            6'd23: e = '{"micro", 3'd5, 2'd2, 24'hC2B500};
            6'd24: e = '{"para", 3'd4, 2'd2, 24'hC2B600};
            6'd25: e = '{"sect", 3'd4, 2'd2, 24'hC2A700};
            6'd26: e = '{"dagger", 3'd6, 2'd3, 24'hE280A0};
            6'd27: e = '{"bull", 3'd4, 2'd3, 24'hE280A2};
            6'd28: e = '{"larr", 3'd4, 2'd3, 24'hE28690};
            6'd29: e = '{"rarr", 3'd4, 2'd3, 24'hE28692};
            6'd30: e = '{"harr", 3'd4, 2'd3, 24'hE28694};
            6'd31: e = '{"auml", 3'd4, 2'd2, 24'hC3A400};
            6'd32: e = '{"ouml", 3'd4, 2'd2, 24'hC3B600};
            6'd33: e = '{"uuml", 3'd4, 2'd2, 24'hC3BC00};
            6'd34: e = '{"szlig", 3'd5, 2'd2, 24'hC39F00};
            6'd35: e = '{"eacute", 3'd6, 2'd2, 24'hC3A900};
            6'd36: e = '{"egrave", 3'd6, 2'd2, 24'hC3A800};
            6'd37: e = '{"agrave", 3'd6, 2'd2, 24'hC3A000};
            6'd38: e = '{"ccedil", 3'd6, 2'd2, 24'hC3A700};
            6'd39: e = '{"euro", 3'd4, 2'd3, 24'hE282AC};
            6'd40: e = '{"pound", 3'd5, 2'd2, 24'hC2A300};
            6'd41: e = '{"yen", 3'd3, 2'd2, 24'hC2A500};
            6'd42: e = '{"cent", 3'd4, 2'd2, 24'hC2A200};
            6'd43: e = '{"AElig", 3'd5, 2'd2, 24'hC38600};
            6'd44: e = '{"Dagger", 3'd6, 2'd3, 24'hE280A1};
            6'd45: e = '{"Auml", 3'd4, 2'd2, 24'hC38400};
            6'd46: e = '{"Ouml", 3'd4, 2'd2, 24'hC39600};
            6'd47: e = '{"Uuml", 3'd4, 2'd2, 24'hC39C00};
            6'd48: e = '{"ge", 3'd2, 2'd3, 24'hE289A5};
            6'd49: e = '{"le", 3'd2, 2'd3, 24'hE289A4};
            6'd50: e = '{"ne", 3'd2, 2'd3, 24'hE289A0};
            default: e = '{48'd0, 3'd7, 2'd0, 24'd0};  // length 7 never matches
         endcase
         e.name = e.name << (8 * (NAME_MAX - int'(e.nlen)));
         return e;
      end
   endfunction

endpackage

// ===== src/mesc_front.sv =====
module mesc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [7:0]         text_byte,
   input  logic               end_of_text,
   output logic               item_valid,
   output mesc_pkg::item_type item,
   input  logic               item_pop
);

   localparam int PW = $clog2(mesc_pkg::REQQ_DEPTH);

   mesc_pkg::item_type        slot_ff [mesc_pkg::REQQ_DEPTH];
   logic [PW-1:0]             wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]               cnt_ff, cnt_in;
   logic                      do_push, do_pop;

   assign full       = (cnt_ff == (PW+1)'(mesc_pkg::REQQ_DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign item       = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // classification is done on the way in
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= '{text_byte, end_of_text, mesc_pkg::classify(text_byte)};
      end
   end

endmodule

// ===== src/mesc_rsp_fifo.sv =====
module mesc_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  mesc_pkg::rsp_type wr_data,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output mesc_pkg::rsp_type rd_data
);

   localparam int PW = $clog2(mesc_pkg::RSPQ_DEPTH);

   mesc_pkg::rsp_type slot_ff [mesc_pkg::RSPQ_DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]       cnt_ff, cnt_in;
   logic              do_wr, do_rd;

   assign full    = (cnt_ff == (PW+1)'(mesc_pkg::RSPQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = slot_ff[rd_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = pop && !empty;

   always_comb begin
      wr_in  = do_wr ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_rd ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(do_wr) - (PW+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ff] <= wr_data;
      end
   end

endmodule

// ===== src/mesc_engine.sv =====
module mesc_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  mesc_pkg::item_type item,
   output logic               item_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output mesc_pkg::rsp_type  rsp_data
);

   localparam int AW = mesc_pkg::MEM_AW;
   localparam int RS = mesc_pkg::ROM_SIZE;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_FEED  = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_END   = 3'd4;

   // stream memory: the held reference and the bytes still to replay
   logic [7:0]    mem [mesc_pkg::MEM_DEPTH];
   logic [7:0]    rd_ff;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] wp_ff, wp_in, p_ff, p_in, bstart_ff, bstart_in;
   logic [5:0]    fill_ff, fill_in;
   logic          bs_ff, bs_in, last_ff, last_in;
   logic          isnum_ff, isnum_in, hexm_ff, hexm_in, bad_ff, bad_in;
   logic [3:0]    ndig_ff, ndig_in;
   logic [31:0]   cp_ff, cp_in;
   logic [RS-1:0] match_ff, match_in;
   logic [23:0]   ebuf_ff, ebuf_in;
   logic [1:0]    ecnt_ff, ecnt_in;
   logic [7:0]    hold_ff, hold_in;
   logic          holdv_ff, holdv_in;

   logic          feed;
   logic [7:0]    fb;
   logic [2:0]    fcls;
   logic [AW-1:0] fpos, p_after, p_base, wp_next;
   logic [7:0]    el [4];
   logic [2:0]    en;
   logic          fail, go, hit, dig_ok;
   logic [5:0]    fill_new;
   logic [2:0]    j;
   logic [3:0]    d;
   logic [34:0]   u8;
   logic          emit_v;
   logic [7:0]    emit_b;
   logic          finish;
   mesc_pkg::entry_type ent;

   function automatic logic [34:0] utf8(input logic [31:0] cp_raw);
      logic [31:0] c;
      logic [31:0] b;
      logic [2:0]  n;
      begin
         c = cp_raw;
         if (c == 32'd0 || c > 32'h10FFFF || (c >= 32'hD800 && c <= 32'hDFFF)) c = 32'hFFFD;
         if (c < 32'h80) begin
            b = {c[7:0], 24'd0};
            n = 3'd1;
         end else if (c < 32'h800) begin
            b = {3'b110, c[10:6], 2'b10, c[5:0], 16'd0};
            n = 3'd2;
         end else if (c < 32'h10000) begin
            b = {4'b1110, c[15:12], 2'b10, c[11:6], 2'b10, c[5:0], 8'd0};
            n = 3'd3;
         end else begin
            b = {5'b11110, c[20:18], 2'b10, c[17:12], 2'b10, c[11:6], 2'b10, c[5:0]};
            n = 3'd4;
         end
         return {b, n};
      end
   endfunction

   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      p_in      = p_ff;
      bstart_in = bstart_ff;
      fill_in   = fill_ff;
      bs_in     = bs_ff;
      last_in   = last_ff;
      isnum_in  = isnum_ff;
      hexm_in   = hexm_ff;
      bad_in    = bad_ff;
      ndig_in   = ndig_ff;
      cp_in     = cp_ff;
      match_in  = match_ff;
      ebuf_in   = ebuf_ff;
      ecnt_in   = ecnt_ff;
      item_pop  = 1'b0;
      emit_v    = 1'b0;
      emit_b    = 8'd0;
      finish    = 1'b0;
      feed      = 1'b0;
      fb        = rd_ff;
      fcls      = mesc_pkg::classify(rd_ff);
      fpos      = p_ff - 1'b1;
      p_after   = p_ff;
      wp_next   = wp_ff;
      el        = '{default: 8'd0};
      en        = 3'd0;
      fail      = 1'b0;
      go        = 1'b1;
      hit       = 1'b0;
      dig_ok    = 1'b0;
      fill_new  = fill_ff + 6'd1;
      j         = 3'd0;
      d         = 4'd0;
      u8        = utf8(cp_ff);
      p_base    = p_ff;
      ent       = mesc_pkg::rom_entry(6'd0);

      case (state_ff)
         S_IDLE: begin
            if (item_valid && !rsp_full) begin
               item_pop = 1'b1;
               feed     = 1'b1;
               fb       = item.text_byte;
               fcls     = item.cls;
               fpos     = wp_ff;
               wp_next  = wp_ff + 1'b1;
               wp_in    = wp_next;
               p_after  = wp_next;
               last_in  = item.end_of_text;
            end
         end
         S_FETCH: begin
            p_in     = p_ff + 1'b1;
            state_in = S_FEED;
         end
         S_FEED: begin
            if (!rsp_full) feed = 1'b1;
         end
         S_EMIT: begin
            if (!rsp_full) begin
               emit_v  = 1'b1;
               emit_b  = ebuf_ff[23:16];
               ebuf_in = {ebuf_ff[15:0], 8'd0};
               ecnt_in = ecnt_ff - 2'd1;
               if (ecnt_ff == 2'd1) state_in = (p_ff == wp_ff) ? S_END : S_FETCH;
            end
         end
         S_END: begin
            if (!rsp_full) begin
               if (last_ff && fill_ff != 6'd0) begin
                  // open reference at end of text: give '&' and rescan the rest
                  emit_v   = 1'b1;
                  emit_b   = mesc_pkg::CH_AMP;
                  fill_in  = 6'd0;
                  p_in     = bstart_ff + 1'b1;
                  state_in = (bstart_ff + 1'b1 == wp_ff) ? S_END : S_FETCH;
               end else if (last_ff && bs_ff) begin
                  emit_v = 1'b1;
                  emit_b = mesc_pkg::CH_BSLASH;
                  bs_in  = 1'b0;
               end else begin
                  finish   = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (feed) begin
         if (fill_ff != 6'd0) begin
            if (fcls == mesc_pkg::CLS_SEMI) begin
               if (fill_ff == 6'd1) begin
                  fail = 1'b1;
               end else if (isnum_ff) begin
                  if (!bad_ff && ndig_ff != 4'd0 &&
                      ndig_ff <= 4'(mesc_pkg::NUMERIC_DIGITS_MAX)) begin
                     el[0] = u8[34:27];
                     el[1] = u8[26:19];
                     el[2] = u8[18:11];
                     el[3] = u8[10:3];
                     en    = u8[2:0];
                  end else begin
                     fail = 1'b1;
                  end
               end else begin
                  for (int k = 0; k < RS; k++) begin
                     if (match_ff[k] &&
                         {3'd0, mesc_pkg::rom_entry(6'(k)).nlen} == fill_ff - 6'd1) begin
                        hit = 1'b1;
                        ent = mesc_pkg::rom_entry(6'(k));
                     end
                  end
                  if (hit) begin
                     el[0] = ent.val[23:16];
                     el[1] = ent.val[15:8];
                     el[2] = ent.val[7:0];
                     en    = {1'b0, ent.vlen};
                  end else begin
                     fail = 1'b1;
                  end
               end
               if (!fail) fill_in = 6'd0;
            end else begin
               // incremental decode of the body byte at index fill_ff
               if (fill_ff == 6'd1) isnum_in = (fb == mesc_pkg::CH_HASH);
               if (isnum_ff && fill_ff >= 6'd2) begin
                  if (fill_ff == 6'd2 && (fb == 8'h78 || fb == 8'h58)) begin
                     hexm_in = 1'b1;
                  end else begin
                     if (fb >= 8'h30 && fb <= 8'h39) begin
                        d      = 4'(fb - 8'h30);
                        dig_ok = 1'b1;
                     end else if (hexm_ff && fb >= 8'h61 && fb <= 8'h66) begin
                        d      = 4'(fb - 8'h57);
                        dig_ok = 1'b1;
                     end else if (hexm_ff && fb >= 8'h41 && fb <= 8'h46) begin
                        d      = 4'(fb - 8'h37);
                        dig_ok = 1'b1;
                     end
                     if (dig_ok) begin
                        cp_in   = hexm_ff ? {cp_ff[27:0], d}
                                          : (cp_ff << 3) + (cp_ff << 1) + {28'd0, d};
                        ndig_in = (ndig_ff == 4'd9) ? ndig_ff : ndig_ff + 4'd1;
                     end else begin
                        bad_in = 1'b1;
                     end
                  end
               end
               if (fill_ff <= 6'(mesc_pkg::NAME_MAX)) begin
                  j = 3'(fill_ff - 6'd1);
                  for (int k = 0; k < RS; k++) begin
                     match_in[k] = match_ff[k] && (mesc_pkg::rom_entry(6'(k)).nlen > j) &&
                                   (mesc_pkg::rom_entry(6'(k)).name[47 - 8*j -: 8] == fb);
                  end
               end else begin
                  match_in = '0;
               end
               if (fill_new == 6'(mesc_pkg::BUF_DEPTH)) fail = 1'b1;
               else fill_in = fill_new;
            end
         end else begin
            if (bs_ff) begin
               bs_in = 1'b0;
               en    = 3'd1;
               if (fcls != mesc_pkg::CLS_PLAIN) begin
                  el[0] = fb;
                  go    = 1'b0;
               end else begin
                  el[0] = mesc_pkg::CH_BSLASH;
               end
            end
            if (go) begin
               if (fcls == mesc_pkg::CLS_BSLASH) begin
                  bs_in = 1'b1;
               end else if (fcls == mesc_pkg::CLS_AMP) begin
                  bstart_in = fpos;
                  fill_in   = 6'd1;
                  isnum_in  = 1'b0;
                  hexm_in   = 1'b0;
                  bad_in    = 1'b0;
                  ndig_in   = 4'd0;
                  cp_in     = 32'd0;
                  match_in  = '1;
               end else if (en == 3'd0) begin
                  el[0] = fb;
                  en    = 3'd1;
               end else begin
                  el[1] = fb;
                  en    = 3'd2;
               end
            end
         end

         if (fail) begin
            // failed reference: give '&' and rescan from the byte after it
            el[0]   = mesc_pkg::CH_AMP;
            en      = 3'd1;
            fill_in = 6'd0;
            p_base  = bstart_ff + 1'b1;
         end else begin
            p_base = p_after;
         end

         if (en != 3'd0) begin
            emit_v = 1'b1;
            emit_b = el[0];
         end
         p_in = p_base;
         if (en > 3'd1) begin
            ebuf_in  = {el[1], el[2], el[3]};
            ecnt_in  = 2'(en - 3'd1);
            state_in = S_EMIT;
         end else begin
            state_in = (p_base == wp_next) ? S_END : S_FETCH;
         end
      end

      // one result is held back so the item's last one can be flagged
      hold_in  = hold_ff;
      holdv_in = holdv_ff;
      rsp_push = 1'b0;
      rsp_data = '{hold_ff, 1'b0, 1'b0};
      if (emit_v) begin
         rsp_push = holdv_ff;
         hold_in  = emit_b;
         holdv_in = 1'b1;
      end else if (finish) begin
         rsp_push = holdv_ff;
         rsp_data = '{hold_ff, last_ff, 1'b1};
         holdv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wp_ff    <= '0;
         p_ff     <= '0;
         fill_ff  <= '0;
         bs_ff    <= 1'b0;
         last_ff  <= 1'b0;
         ecnt_ff  <= '0;
         holdv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         p_ff     <= p_in;
         fill_ff  <= fill_in;
         bs_ff    <= bs_in;
         last_ff  <= last_in;
         ecnt_ff  <= ecnt_in;
         holdv_ff <= holdv_in;
      end
   end

   always_ff @(posedge clock) begin
      bstart_ff <= bstart_in;
      isnum_ff  <= isnum_in;
      hexm_ff   <= hexm_in;
      bad_ff    <= bad_in;
      ndig_ff   <= ndig_in;
      cp_ff     <= cp_in;
      match_ff  <= match_in;
      ebuf_ff   <= ebuf_in;
      hold_ff   <= hold_in;
   end

   always_ff @(posedge clock) begin
      if (item_pop) mem[wp_ff] <= item.text_byte;
      if (state_ff == S_FETCH) rd_ff <= mem[p_ff];
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff < 6'(mesc_pkg::BUF_DEPTH))
      else $error("reference buffer overfilled");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (p_ff == wp_ff))
      else $error("idle with bytes left to scan");

   a_no_bs_in_ref: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != 6'd0) |-> !bs_ff)
      else $error("backslash pending inside a reference");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_idle_flushed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !holdv_ff)
      else $error("held result left over between items");

endmodule

// ===== src/markdown_escape_entity_decoder_core.sv =====
// channel   ports                                       transfer when
// req       req_text_byte, req_end_of_text, push/full   push & !full
// rsp       rsp_out_byte, rsp_text_done, rsp_run_last   pop & !empty
//           empty/pop
// In the engine a plain byte is decoded, then its item is closed; each replayed
// byte is read from memory, then decoded; extra reference output bytes go out in S_EMIT.
// A failed reference rescans up to 33 held bytes from the stream memory.
// Reset is synchronous; the engine is ready right after reset.
// A full result queue stalls the engine; a 2-entry input queue keeps accepting until it is full.
module markdown_escape_entity_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   input  logic       push,
   output logic       full,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_text_done,
   output logic       rsp_run_last,
   output logic       empty,
   input  logic       pop
);

   mesc_pkg::item_type item;
   mesc_pkg::rsp_type  push_data, head;
   logic               item_valid, item_pop, q_full, q_push;

   mesc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop)
   );

   mesc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_full   (q_full),
      .rsp_push   (q_push),
      .rsp_data   (push_data)
   );

   mesc_rsp_fifo u_rsp (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (push_data),
      .full    (q_full),
      .empty   (empty),
      .pop     (pop),
      .rd_data (head)
   );

   assign rsp_out_byte  = head.out_byte;
   assign rsp_text_done = head.text_done;
   assign rsp_run_last  = head.run_last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

   typedef struct {
      logic [7:0] text_byte;
      logic       end_of_text;
      logic       typed;       // expected result given in the table
      logic [7:0] typed_byte;
   } stim_row_type;

   logic       clock = 0;
   logic       reset = 1;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_end_of_text = 0;
   logic       push = 0;
   logic       full;
   logic [7:0] rsp_out_byte;
   logic       rsp_text_done;
   logic       rsp_run_last;
   logic       empty;
   logic       pop = 0;

   markdown_escape_entity_decoder_core dut (
      .clock(clock), .reset(reset),
      .req_text_byte(req_text_byte), .req_end_of_text(req_end_of_text),
      .push(push), .full(full),
      .rsp_out_byte(rsp_out_byte), .rsp_text_done(rsp_text_done),
      .rsp_run_last(rsp_run_last), .empty(empty), .pop(pop)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // ---------------- decoder predictor ----------------
   string      ent_name[mesc_pkg::ROM_SIZE] = '{
      "amp", "lt", "gt", "quot", "apos", "nbsp", "copy", "reg", "trade", "hellip",
      "mdash", "ndash", "lsquo", "rsquo", "ldquo", "rdquo", "laquo", "raquo", "deg",
      "plusmn", "times", "divide", "frac12", "micro", "para", "sect", "dagger", "bull",
      "larr", "rarr", "harr", "auml", "ouml", "uuml", "szlig", "eacute", "egrave",
      "agrave", "ccedil", "euro", "pound", "yen", "cent", "AElig", "Dagger", "Auml",
      "Ouml", "Uuml", "ge", "le", "ne"};
   logic [23:0] ent_utf8[mesc_pkg::ROM_SIZE] = '{
      24'h260000, 24'h3C0000, 24'h3E0000, 24'h220000, 24'h270000, 24'hC2A000,
      24'hC2A900, 24'hC2AE00, 24'hE284A2, 24'hE280A6, 24'hE28094, 24'hE28093,
      24'hE28098, 24'hE28099, 24'hE2809C, 24'hE2809D, 24'hC2AB00, 24'hC2BB00,
      24'hC2B000, 24'hC2B100, 24'hC39700, 24'hC3B700, 24'hC2BD00, 24'hC2B500,
      24'hC2B600, 24'hC2A700, 24'hE280A0, 24'hE280A2, 24'hE28690, 24'hE28692,
      24'hE28694, 24'hC3A400, 24'hC3B600, 24'hC3BC00, 24'hC39F00, 24'hC3A900,
      24'hC3A800, 24'hC3A000, 24'hC3A700, 24'hE282AC, 24'hC2A300, 24'hC2A500,
      24'hC2A200, 24'hC38600, 24'hE280A1, 24'hC38400, 24'hC39600, 24'hC39C00,
      24'hE289A5, 24'hE289A4, 24'hE289A0};
   int          ent_len[mesc_pkg::ROM_SIZE] = '{
      1, 1, 1, 1, 1, 2, 2, 2, 3, 3, 3, 3, 3, 3, 3, 3, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2,
      3, 3, 3, 3, 3, 2, 2, 2, 2, 2, 2, 2, 2, 3, 2, 2, 2, 2, 3, 2, 2, 2, 3, 3, 3};

   logic [7:0] held_ref[mesc_pkg::BUF_DEPTH];
   int         held_fill = 0;
   logic       slash_open = 0;
   logic [7:0] rescan_q[$];
   mesc_pkg::rsp_type step_out[$];
   mesc_pkg::rsp_type expected_out[$];
   int         errors = 0;

   function automatic logic is_punct(input logic [7:0] b);
      return (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
             (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
   endfunction

   task automatic put_byte(input logic [7:0] b);
      step_out.push_back('{b, 1'b0, 1'b0});
   endtask

   task automatic put_code_point(input logic [31:0] cp);
      if (cp == 0 || cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) cp = 32'hFFFD;
      if (cp < 32'h80) put_byte(cp[7:0]);
      else if (cp < 32'h800) begin
         put_byte(8'hC0 | cp[10:6]);
         put_byte(8'h80 | cp[5:0]);
      end else if (cp < 32'h10000) begin
         put_byte(8'hE0 | cp[15:12]);
         put_byte(8'h80 | cp[11:6]);
         put_byte(8'h80 | cp[5:0]);
      end else begin
         put_byte(8'hF0 | cp[20:18]);
         put_byte(8'h80 | cp[17:12]);
         put_byte(8'h80 | cp[11:6]);
         put_byte(8'h80 | cp[5:0]);
      end
   endtask

   // body is held_ref[1 .. semi-1]
   task automatic resolve_ref(input int semi, output logic ok);
      int         blen, first, i, k;
      logic       hex, same;
      logic [7:0] c;
      logic [31:0] cp, d;
      blen = semi - 1;
      ok = 0;
      if (blen == 0) return;
      if (held_ref[1] == mesc_pkg::CH_HASH) begin
         hex = blen > 2 && (held_ref[2] == "x" || held_ref[2] == "X");
         first = hex ? 3 : 2;
         if (semi <= first || semi - first > mesc_pkg::NUMERIC_DIGITS_MAX) return;
         cp = 0;
         for (i = first; i < semi; i++) begin
            c = held_ref[i];
            if (c >= "0" && c <= "9") d = c - "0";
            else if (hex && c >= "a" && c <= "f") d = c - "a" + 10;
            else if (hex && c >= "A" && c <= "F") d = c - "A" + 10;
            else return;
            cp = cp * (hex ? 16 : 10) + d;
         end
         put_code_point(cp);
         ok = 1;
         return;
      end
      for (k = 0; k < mesc_pkg::ROM_SIZE; k++) begin
         if (ent_name[k].len() != blen) continue;
         same = 1;
         for (i = 0; i < blen; i++)
            if (ent_name[k][i] != held_ref[1 + i]) same = 0;
         if (same) begin
            for (i = 0; i < ent_len[k]; i++) put_byte(ent_utf8[k][23 - 8 * i -: 8]);
            ok = 1;
            return;
         end
      end
   endtask

   task automatic abandon_ref();
      int i;
      put_byte(mesc_pkg::CH_AMP);
      for (i = held_fill - 1; i >= 1; i--) rescan_q.push_front(held_ref[i]);
      held_fill = 0;
   endtask

   task automatic scan_byte(input logic [7:0] b);
      logic ok;
      if (held_fill > 0) begin
         if (held_fill < mesc_pkg::BUF_DEPTH) held_ref[held_fill++] = b;
         if (b == mesc_pkg::CH_SEMI) begin
            resolve_ref(held_fill - 1, ok);
            if (ok) held_fill = 0;
            else abandon_ref();
         end else if (held_fill >= mesc_pkg::BUF_DEPTH) abandon_ref();
         return;
      end
      if (slash_open) begin
         slash_open = 0;
         if (is_punct(b)) begin
            put_byte(b);
            return;
         end
         put_byte(mesc_pkg::CH_BSLASH);
      end
      if (b == mesc_pkg::CH_BSLASH) slash_open = 1;
      else if (b == mesc_pkg::CH_AMP) begin
         held_ref[0] = mesc_pkg::CH_AMP;
         held_fill = 1;
      end else put_byte(b);
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last);
      step_out.delete();
      rescan_q = '{b};
      forever begin
         while (rescan_q.size() > 0) scan_byte(rescan_q.pop_front());
         if (!last) break;
         if (held_fill > 0) begin
            abandon_ref();
            continue;
         end
         if (slash_open) begin
            slash_open = 0;
            put_byte(mesc_pkg::CH_BSLASH);
         end
         break;
      end
      if (step_out.size() > 0) begin
         step_out[$].run_last = 1;
         step_out[$].text_done = last;
      end
   endtask

   // ---------------- stimulus ----------------
   stim_row_type stim_q[$];
   stim_row_type accepted_q[$];   // rows in the order they were driven

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         stim_q.push_back('{s[i], i == s.len() - 1, 1'b0, 8'h00});
   endtask

   task automatic add_typed(input logic [7:0] b, input logic eot);
      stim_q.push_back('{b, eot, 1'b1, b});
   endtask

   function automatic string hex_str(input logic [31:0] v, input logic upper);
      string s;
      s = upper ? $sformatf("%0X", v) : $sformatf("%0x", v);
      return s;
   endfunction

   task automatic add_random_text();
      string s, body;
      int    pieces, p, k, n;
      logic [31:0] v;
      s = "";
      pieces = $urandom_range(1, 5);
      for (p = 0; p < pieces; p++) begin
         case ($urandom_range(0, 7))
            0, 1: begin
               body = ent_name[$urandom_range(0, mesc_pkg::ROM_SIZE - 1)];
               if ($urandom_range(0, 4) == 0) body[0] = body[0] ^ 8'h20;  // wrong case
               s = {s, "&", body, ";"};
            end
            2: begin
               case ($urandom_range(0, 3))
                  0: v = $urandom_range(0, 32'h7FF);
                  1: v = $urandom_range(32'hD7F0, 32'hE010);
                  2: v = $urandom_range(32'h10000, 32'h110010);
                  default: v = $urandom;
               endcase
               if ($urandom_range(0, 1)) s = {s, "&#", $sformatf("%0d", v % 100000000), ";"};
               else s = {s, "&#", ($urandom_range(0, 1) ? "x" : "X"),
                         hex_str(v, $urandom_range(0, 1)), ";"};
            end
            3: begin
               s = {s, "\\", " "};
               s[s.len() - 1] = $urandom_range(1, 255);
            end
            4: begin
               n = $urandom_range(1, 4);
               for (k = 0; k < n; k++) begin
                  s = {s, " "};
                  s[s.len() - 1] = $urandom_range(1, 255);
               end
            end
            5: s = {s, "&", ($urandom_range(0, 1) ? "#x12g;" : "bogus")};
            6: s = {s, "plain"};
            default: s = {s, "&#", $sformatf("%0d", $urandom_range(0, 999)), "a;"};
         endcase
      end
      for (k = 0; k < s.len(); k++)
         stim_q.push_back('{s[k], k == s.len() - 1, 1'b0, 8'h00});
      // a zero byte cannot sit in a string, so add one now and then
      if ($urandom_range(0, 9) == 0) begin
         stim_q[$].end_of_text = 0;
         stim_q.push_back('{8'h00, 1'b1, 1'b0, 8'h00});
      end
   endtask

   // ---------------- scoreboard ----------------
   always @(posedge clock) begin
      mesc_pkg::rsp_type got, want;
      stim_row_type      row;
      if (!reset) begin
         if (push && !full) begin
            row = accepted_q.pop_front();
            decode_byte(row.text_byte, row.end_of_text);
            if (row.typed) expected_out.push_back('{row.typed_byte, row.end_of_text, 1'b1});
            else foreach (step_out[i]) expected_out.push_back(step_out[i]);
         end
         if (pop && !empty) begin
            got = '{rsp_out_byte, rsp_text_done, rsp_run_last};
            if (expected_out.size() == 0) begin
               $error("unexpected transfer: out_byte %h", got.out_byte);
               errors++;
            end else begin
               want = expected_out.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  $error("out_byte expected %h actual %h", want.out_byte, got.out_byte);
                  errors++;
               end
               if (got.text_done !== want.text_done) begin
                  $error("text_done expected %b actual %b", want.text_done, got.text_done);
                  errors++;
               end
               if (got.run_last !== want.run_last) begin
                  $error("run_last expected %b actual %b", want.run_last, got.run_last);
                  errors++;
               end
            end
         end
      end
   end

   // ---------------- receiver ----------------
   logic hold_off = 0;
   always @(negedge clock) begin
      int mode_left, mode;
      if (hold_off) begin
         pop <= 0;
         repeat (300) @(negedge clock);
         hold_off = 0;
      end
      if (mode_left == 0) begin
         mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (mode)
         0: pop <= 1;
         1: pop <= ($urandom_range(0, 3) != 0);
         default: pop <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // ---------------- timeout ----------------
   int cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------- sender ----------------
   initial begin
      int           burst, n;
      stim_row_type row;
      // directed: extremes with typed results, then each special case
      add_typed("A", 1);
      add_typed(8'h00, 0);
      add_typed(8'hFF, 1);
      add_text("&amp;");
      add_text("\\*");
      add_text("\\q");
      add_text("&;");
      add_text("&#x;");
      add_text("&#0;");
      add_text("&Q");
      // long reference with no semicolon in reach
      add_text("&abcdefghijklmnopqrstuvwxyzABCDEFGHIJ");
      while (stim_q.size() < 95) add_random_text();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      burst = 0;
      n = 0;
      while (stim_q.size() > 0) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            push = 0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end
         if (n == 40) hold_off = 1;
         if (n == 90) begin
            push = 0;
            while (expected_out.size() > 0) @(negedge clock);
         end
         row = stim_q.pop_front();
         accepted_q.push_back(row);
         req_text_byte = row.text_byte;
         req_end_of_text = row.end_of_text;
         push = 1;
         do @(posedge clock); while (full);
         @(negedge clock);
         burst--;
         n++;
      end
      push = 0;
      while (expected_out.size() > 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (errors == 0 && expected_out.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
